### rtl/pfc_pkg.sv
// Shared constants and functions for the Playfair digraph cipher.
`timescale 1ns / 1ps
`default_nettype none
package pfc_pkg;
  localparam logic [1:0] CmdKeyChar = 2'd0;
  localparam logic [1:0] CmdKeyDone = 2'd1;
  localparam logic [1:0] CmdTextChar = 2'd2;
  localparam logic [1:0] CmdEndText = 2'd3;
  localparam logic [4:0] LetterX = 5'd23;
  localparam logic [4:0] LetterI = 5'd8;
  localparam logic [4:0] LetterJ = 5'd9;
  localparam logic [4:0] NoLetter = 5'd26;
  localparam logic [5:0] NoneMark = 6'd32;
  localparam logic [4:0] SquareSize = 5'd25;

  // ASCII to letter code, J folded into I, NoLetter for anything else
  function automatic logic [4:0] letter_code(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61;
    else v = {3'd0, NoLetter};
    if (v[4:0] == LetterJ) v = {3'd0, LetterI};
    return v[4:0];
  endfunction

  function automatic logic [2:0] add_mod5(input logic [2:0] a, input logic [2:0] s);
    logic [3:0] t;
    t = {1'b0, a} + {1'b0, s};
    if (t >= 4'd5) t = t - 4'd5;
    return t[2:0];
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    logic [4:0] t;
    t = {r, 2'b00} + {2'b00, r} + {2'b00, c};
    return t;
  endfunction

  // row of a square cell, cells 0 to 24
  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [4:0] t;
    t = p - cell_of(row_of(p), 3'd0);
    return t[2:0];
  endfunction
endpackage
`default_nettype wire

### rtl/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher.
// Usage: words arrive on the input channel (cmd_i, char_in_i, valid/ready).
// Key characters build the 5x5 square. Key done fills the rest of the
// square, scanning one letter per cycle, then builds the position table,
// holding the input off meanwhile. A text letter that completes a pair
// keeps the sequencer busy: StLook1 does the two position reads, StLook2
// the two square reads (one read port on each memory) and StEmit loads up
// to two result words into the output buffer. End of text emits up to two
// words, the last flagged; padding in encrypt mode costs the same as a pair.
// Input is accepted only when the sequencer is idle and the output buffer
// is empty, so a stalled receiver holds the input off.
// Reset clears control state and the used map; square contents are
// undefined until the key is finished. The user must write decrypt_mode_i
// with decrypt_mode_we_i only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module playfair_digraph_cipher
  import pfc_pkg::*;
#(
  parameter int unsigned MAX_PAIRS = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       decrypt_mode_we_i,
  input  wire logic       decrypt_mode_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] char_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_letter_o,
  output logic            has_letter_o,
  output logic            last_o,
  output logic            odd_length_o
);
  localparam int unsigned PW = $clog2(MAX_PAIRS + 1);

  typedef enum logic [2:0] {
    StIdle, StFill, StPos, StLook1, StLook2, StEmit
  } state_e;

  typedef struct packed {
    logic [4:0] letter;
    logic       has;
    logic       last;
    logic       odd;
  } word_t;

  state_e state_q;
  logic [4:0] sq_mem [25];
  logic [4:0] pos_mem [26];
  logic [25:0] used_q;
  logic [4:0] fill_q, scan_q;
  logic ready_q, dec_q;
  logic [4:0] pend_q; logic pend_v_q;
  logic [4:0] h0_q, h1_q; logic held_q;
  logic [5:0] bef_q;
  logic [PW-1:0] pairs_q;
  logic [4:0] a_q, b_q, pa_q, pb_q, o1_q;
  logic end_q;
  word_t buf_q [2];
  logic [1:0] cnt_q;
  logic head_q;
  logic [4:0] sq_rd_q, pos_rd_q;

  logic acc, out_acc;
  logic [4:0] v;
  assign v = letter_code(char_in_i);
  assign in_ready_o = (state_q == StIdle) && (cnt_q == 2'd0);
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_acc = out_valid_o && out_ready_i;
  assign out_letter_o = buf_q[head_q].has ? 8'h41 + {3'd0, buf_q[head_q].letter} : 8'd0;
  assign has_letter_o = buf_q[head_q].has;
  assign last_o = buf_q[head_q].last;
  assign odd_length_o = buf_q[head_q].odd;

  // cipher geometry from the two positions
  logic [2:0] ra, ca, rb, cb, st;
  logic [4:0] c1, c2;
  always_comb begin
    ra = row_of(pa_q); ca = col_of(pa_q);
    rb = row_of(pb_q); cb = col_of(pb_q);
    st = dec_q ? 3'd4 : 3'd1;
    if (ra == rb) begin
      c1 = cell_of(ra, add_mod5(ca, st));
      c2 = cell_of(rb, add_mod5(cb, st));
    end else if (ca == cb) begin
      c1 = cell_of(add_mod5(ra, st), ca);
      c2 = cell_of(add_mod5(rb, st), cb);
    end else begin
      c1 = cell_of(ra, cb);
      c2 = cell_of(rb, ca);
    end
  end

  // memories: square and positions, one write and one registered read each
  logic sq_we, pos_we;
  logic [4:0] sq_wa, sq_wd, sq_ra, pos_wa, pos_wd, pos_ra;
  always_ff @(posedge clk_i) begin
    if (sq_we) sq_mem[sq_wa] <= sq_wd;
    sq_rd_q <= sq_mem[sq_ra];
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_q <= pos_mem[pos_ra];
  end

  // the first lookup cycle reads pos[a]; b position is read in StLook1
  logic [1:0] ph_q;
  logic fill_add;
  logic [4:0] scan_l;
  always_comb begin
    scan_l = scan_q;
    fill_add = (state_q == StFill) && (scan_q != LetterJ) && !used_q[scan_q]
               && (fill_q < SquareSize);
    sq_we = 1'b0; sq_wa = fill_q; sq_wd = scan_l;
    pos_we = 1'b0; pos_wa = sq_rd_q; pos_wd = scan_q;
    sq_ra = scan_q; pos_ra = a_q;
    if (acc && cmd_i == CmdKeyChar && v != NoLetter) begin
      sq_we = (ready_q || !used_q[v]) && (ready_q || fill_q < SquareSize);
      sq_wa = ready_q ? 5'd0 : fill_q; sq_wd = v;
    end else if (fill_add) begin
      sq_we = 1'b1;
    end
    if (state_q == StPos && ph_q != 2'd0) begin
      pos_we = 1'b1; pos_wa = sq_rd_q; pos_wd = scan_q - 5'd1;
    end
    if (state_q == StLook1) pos_ra = (ph_q == 2'd0) ? a_q : b_q;
    if (state_q == StLook2) sq_ra = (ph_q == 2'd0) ? c1 : c2;
  end

  // pushes into output buffer
  function automatic word_t mk(input logic [4:0] l, input logic h);
    word_t w;
    w.letter = l; w.has = h; w.last = 1'b0; w.odd = 1'b0;
    return w;
  endfunction

  word_t e_w0, e_w1;
  logic [1:0] e_n;
  always_comb begin
    e_w0 = mk(5'd0, 1'b0); e_w1 = mk(5'd0, 1'b0); e_n = 2'd0;
    if (held_q) begin
      if (h1_q == LetterX) begin
        e_w0 = mk(h0_q, 1'b1); e_n = 2'd1;
      end else if (h0_q == LetterX && bef_q == {1'b0, h1_q}) begin
        e_w0 = mk(h1_q, 1'b1); e_n = 2'd1;
      end else begin
        e_w0 = mk(h0_q, 1'b1); e_w1 = mk(h1_q, 1'b1); e_n = 2'd2;
      end
    end
    if (e_n == 2'd0) e_n = 2'd1;
    if (e_n == 2'd1) begin
      e_w0.last = 1'b1; e_w0.odd = dec_q & pend_v_q;
    end else begin
      e_w1.last = 1'b1; e_w1.odd = dec_q & pend_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; used_q <= '0; fill_q <= '0; scan_q <= '0;
      ready_q <= 1'b0; dec_q <= 1'b0; pend_q <= '0; pend_v_q <= 1'b0;
      h0_q <= '0; h1_q <= '0; held_q <= 1'b0; bef_q <= NoneMark;
      pairs_q <= '0; cnt_q <= '0; head_q <= 1'b0; ph_q <= '0;
      a_q <= '0; b_q <= '0; pa_q <= '0; pb_q <= '0; o1_q <= '0; end_q <= 1'b0;
      buf_q[0] <= '0; buf_q[1] <= '0;
    end else begin
      if (out_acc) begin
        head_q <= ~head_q; cnt_q <= cnt_q - 2'd1;
      end
      if (decrypt_mode_we_i) begin
        dec_q <= decrypt_mode_i;
        pend_v_q <= 1'b0; held_q <= 1'b0; bef_q <= NoneMark; pairs_q <= '0;
      end
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            unique case (cmd_i)
              CmdKeyChar: begin
                if (v != NoLetter) begin
                  if (ready_q) begin
                    ready_q <= 1'b0; used_q <= 26'd1 << v; fill_q <= 5'd1;
                    pend_v_q <= 1'b0; held_q <= 1'b0; bef_q <= NoneMark;
                    pairs_q <= '0;
                  end else if (!used_q[v]) begin
                    used_q[v] <= 1'b1;
                    if (fill_q < SquareSize) fill_q <= fill_q + 5'd1;
                  end
                end
              end
              CmdKeyDone: begin
                scan_q <= '0;
                state_q <= ready_q ? StIdle : StFill;
              end
              CmdTextChar: begin
                if (v != NoLetter && ready_q && 32'(pairs_q) < MAX_PAIRS) begin
                  if (!pend_v_q) begin
                    pend_q <= v; pend_v_q <= 1'b1;
                  end else begin
                    a_q <= pend_q; end_q <= 1'b0;
                    if (!dec_q && pend_q == v) begin
                      b_q <= LetterX;
                    end else begin
                      b_q <= v; pend_v_q <= 1'b0;
                    end
                    if (!dec_q && pend_q == v) pend_q <= v;
                    pairs_q <= pairs_q + PW'(1);
                    ph_q <= '0; state_q <= StLook1;
                  end
                end
              end
              CmdEndText: begin
                if (!dec_q && pend_v_q && 32'(pairs_q) < MAX_PAIRS) begin
                  a_q <= pend_q; b_q <= LetterX; end_q <= 1'b1;
                  ph_q <= '0; state_q <= StLook1;
                end else begin
                  buf_q[0] <= e_w0; buf_q[1] <= e_w1;
                  head_q <= 1'b0; cnt_q <= e_n;
                  pend_v_q <= 1'b0; held_q <= 1'b0; bef_q <= NoneMark; pairs_q <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        StFill: begin
          if (fill_add) begin
            used_q[scan_q] <= 1'b1; fill_q <= fill_q + 5'd1;
          end
          if (scan_q == 5'd25) begin
            scan_q <= '0; ph_q <= '0; state_q <= StPos;
          end else scan_q <= scan_q + 5'd1;
        end
        StPos: begin
          // sq_ra = scan_q; pos is written in the next cycle from the registered read
          ph_q <= 2'd1;
          if (ph_q != 2'd0 && scan_q == SquareSize) begin
            state_q <= StIdle; ready_q <= 1'b1;
          end else scan_q <= scan_q + 5'd1;
        end
        StLook1: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd1) pa_q <= pos_rd_q;
          if (ph_q == 2'd2) begin
            pb_q <= pos_rd_q; ph_q <= '0; state_q <= StLook2;
          end
        end
        StLook2: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd1) o1_q <= sq_rd_q;
          if (ph_q == 2'd2) state_q <= StEmit;
        end
        StEmit: begin
          state_q <= StIdle; head_q <= 1'b0;
          if (!dec_q) begin
            buf_q[0] <= mk(o1_q, 1'b1);
            buf_q[1] <= '{letter: sq_rd_q, has: 1'b1, last: end_q, odd: 1'b0};
            cnt_q <= 2'd2;
            if (end_q) begin
              pend_v_q <= 1'b0; held_q <= 1'b0; bef_q <= NoneMark; pairs_q <= '0;
            end
          end else begin
            if (held_q) begin
              if (!(h0_q == LetterX && bef_q == {1'b0, h1_q})) begin
                buf_q[0] <= mk(h0_q, 1'b1);
                buf_q[1] <= mk(h1_q, 1'b1);
                cnt_q <= (h1_q == LetterX && h0_q == o1_q) ? 2'd1 : 2'd2;
              end else begin
                buf_q[0] <= mk(h1_q, 1'b1);
                cnt_q <= (h1_q == LetterX && h0_q == o1_q) ? 2'd0 : 2'd1;
              end
              bef_q <= {1'b0, h1_q};
            end
            h0_q <= o1_q; h1_q <= sq_rd_q; held_q <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("output buffer overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> cnt_q == 2'd0) else $error("accept with results pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill) |-> !ready_q) else $error("fill while square ready");
endmodule
`default_nettype wire
